/* hdl/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/prqs_pkg.sv */
// Shared types and codes of the priority ready queue scheduler.
// No dependencies; used by every module of the block.
package prqs_pkg;

   typedef enum logic [1:0] {
      KIND_ENQUEUE = 2'd0,
      KIND_REMOVE  = 2'd1,
      KIND_PICK    = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      QOP_NONE   = 2'd0,
      QOP_ENQ    = 2'd1,
      QOP_UNLINK = 2'd2,
      QOP_POP    = 2'd3
   } qop_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_PREEMPT_ENABLE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUND_ROBIN_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_LENGTH       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_TASK_ID       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_PRESENT       = 3'd4;

   localparam logic [7:0] SLICE_RESET = 8'd10;
   localparam logic [7:0] SLICE_MAX   = 8'd255;

   // level search result seen by the control logic
   typedef struct packed {
      logic any;      // some level is non-empty
      logic higher;   // a level above the current one is non-empty
      logic cur_set;  // the current level is non-empty
   } find_type;

endpackage

/* hdl/priority_ready_queue_scheduler.sv */
// Priority ready queue scheduler: enqueue, remove, pick and tick on per-level task FIFOs.
// Flow: an accepted word is held in the input register, and its result is registered before it is strobed;
// a pick makes a re-queue pass, then a pop pass, and holds busy during the re-queue pass.
// Throughput: one word per cycle while busy is low; the result is never stalled.
// Reset: synchronous, clears queues, current task and slice count, loads csr defaults.
// Depends on prqs_pkg, prqs_queue, prqs_level_find and assert_macros.svh.
`include "assert_macros.svh"

module priority_ready_queue_scheduler #(
   parameter int unsigned NUM_TASKS  = 32,
   parameter int unsigned NUM_LEVELS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_kind,
   input  logic [4:0]                          req_task_id,
   input  logic [4:0]                          req_task_level,
   output logic                                rsp_valid,
   output logic [4:0]                          rsp_next_task,
   output logic                                rsp_next_valid,
   output logic                                rsp_reschedule,
   output logic                                rsp_ignored,
   input  logic                                csr_we,
   input  logic [prqs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [prqs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   localparam int unsigned TW = $clog2(NUM_TASKS);
   localparam int unsigned LW = $clog2(NUM_LEVELS);

   // configuration registers
   logic       cfg_preempt_ff;
   logic       cfg_rr_ff;
   logic [7:0] cfg_slice_ff;
   logic [4:0] cfg_idle_id_ff;
   logic       cfg_idle_present_ff;

   // input register and pick sequencing
   logic                 req_valid_ff;
   prqs_pkg::kind_type   req_kind_ff;
   logic [4:0]           req_task_ff;
   logic [4:0]           req_level_ff;
   logic                 phase_ff;
   logic                 accept;

   // scheduler state outside the queues
   logic [4:0]    cur_ff,  cur_in;
   logic [LW-1:0] cl_ff,   cl_in;
   logic          cv_ff,   cv_in;
   logic          cr_ff,   cr_in;
   logic [7:0]    sc_ff,   sc_in;

   // result register
   logic       rsp_valid_ff;
   logic [4:0] rsp_task_ff;
   logic       rsp_nvalid_ff;
   logic       rsp_resched_ff, resched_in;
   logic       rsp_ign_ff,     ign_in;

   // queue interface
   prqs_pkg::qop_type q_op;
   logic [TW-1:0]     q_task;
   logic [LW-1:0]     q_level;
   logic [NUM_LEVELS-1:0] q_mask;
   logic              q_queued;
   logic [TW-1:0]     q_pop_task;

   logic [LW-1:0]      top_level;
   prqs_pkg::find_type find;

   // index conversion between 5-bit ids and the store widths
   logic [TW+4:0] t_wide;
   logic [TW+4:0] cur_wide;
   logic [TW+4:0] pop_wide;
   logic [LW+4:0] l_wide;
   logic [TW-1:0] t_idx;
   logic [TW-1:0] cur_idx;
   logic [LW-1:0] l_idx;
   logic          t_ok;
   logic          cur_ok;
   logic          l_ok;
   logic          cur_idle;
   logic          phase1;
   logic          phase2;
   logic [7:0]    sc_inc;

   // a pick holds the input register for its second pass
   assign busy   = req_valid_ff && (req_kind_ff == prqs_pkg::KIND_PICK) && !phase_ff;
   assign accept = start && !busy;
   assign phase1 = busy;
   assign phase2 = req_valid_ff && (req_kind_ff == prqs_pkg::KIND_PICK) && phase_ff;

   always_comb begin
      t_wide   = {{TW{1'b0}}, req_task_ff};
      cur_wide = {{TW{1'b0}}, cur_ff};
      pop_wide = {5'b0, q_pop_task};
      l_wide   = {{LW{1'b0}}, req_level_ff};
      t_idx    = t_wide[TW-1:0];
      cur_idx  = cur_wide[TW-1:0];
      l_idx    = l_wide[LW-1:0];
      t_ok     = t_wide < (TW+5)'(NUM_TASKS);
      cur_ok   = cur_wide < (TW+5)'(NUM_TASKS);
      l_ok     = l_wide < (LW+5)'(NUM_LEVELS);
      cur_idle = cfg_idle_present_ff && (cur_ff == cfg_idle_id_ff);
      sc_inc   = (sc_ff == prqs_pkg::SLICE_MAX) ? sc_ff : sc_ff + 8'd1;
   end

   // queue command: drop out-of-range ids before they reach the store
   always_comb begin
      q_op    = prqs_pkg::QOP_NONE;
      q_task  = t_idx;
      q_level = l_idx;
      if (req_valid_ff) begin
         unique case (req_kind_ff)
            prqs_pkg::KIND_ENQUEUE: begin
               if (t_ok && l_ok) q_op = prqs_pkg::QOP_ENQ;
            end
            prqs_pkg::KIND_REMOVE: begin
               if (t_ok) q_op = prqs_pkg::QOP_UNLINK;
            end
            prqs_pkg::KIND_PICK: begin
               if (phase1) begin
                  // put the running task back at the tail of its level
                  q_task  = cur_idx;
                  q_level = cl_ff;
                  if (cv_ff && cr_ff && !cur_idle && cur_ok) q_op = prqs_pkg::QOP_ENQ;
               end else begin
                  q_level = top_level;
                  if (find.any) q_op = prqs_pkg::QOP_POP;
               end
            end
            prqs_pkg::KIND_TICK: begin
               q_op = prqs_pkg::QOP_NONE;
            end
            default: begin
               q_op = prqs_pkg::QOP_NONE;
            end
         endcase
      end
   end

   // next current task, slice count and response flags
   always_comb begin
      cur_in     = cur_ff;
      cl_in      = cl_ff;
      cv_in      = cv_ff;
      cr_in      = cr_ff;
      sc_in      = sc_ff;
      resched_in = 1'b0;
      ign_in     = 1'b0;
      if (req_valid_ff) begin
         unique case (req_kind_ff)
            prqs_pkg::KIND_ENQUEUE: begin
               ign_in = !(t_ok && l_ok && !q_queued);
            end
            prqs_pkg::KIND_REMOVE: begin
               // ignored only when nothing was unlinked and the task was not running
               ign_in = !(t_ok && q_queued) && !(cv_ff && cr_ff && (cur_ff == req_task_ff));
               if (cv_ff && (cur_ff == req_task_ff)) cr_in = 1'b0;
            end
            prqs_pkg::KIND_PICK: begin
               if (phase1) begin
                  if (cv_ff && cr_ff) cr_in = 1'b0;
               end else if (find.any) begin
                  cur_in = pop_wide[4:0];
                  cl_in  = top_level;
                  cv_in  = 1'b1;
                  cr_in  = 1'b1;
               end else if (cfg_idle_present_ff) begin
                  cur_in = cfg_idle_id_ff;
                  cl_in  = '0;
                  cv_in  = 1'b1;
                  cr_in  = 1'b1;
               end
            end
            prqs_pkg::KIND_TICK: begin
               if (cfg_preempt_ff && cv_ff) begin
                  if (!cr_ff || cur_idle) begin
                     sc_in      = '0;
                     resched_in = 1'b1;
                  end else if (find.any) begin
                     if (find.higher) begin
                        // preempt by a more urgent level
                        sc_in      = '0;
                        resched_in = 1'b1;
                     end else if (cfg_rr_ff && find.cur_set) begin
                        // advance the time slice, rotate when it expires
                        if (sc_inc >= cfg_slice_ff) begin
                           sc_in      = '0;
                           resched_in = 1'b1;
                        end else begin
                           sc_in = sc_inc;
                        end
                     end
                  end
               end
            end
            default: begin
               ign_in = 1'b0;
            end
         endcase
      end
   end

   prqs_queue #(
      .NUM_TASKS  (NUM_TASKS),
      .NUM_LEVELS (NUM_LEVELS)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .op          (q_op),
      .task_idx    (q_task),
      .level_idx   (q_level),
      .level_mask  (q_mask),
      .task_queued (q_queued),
      .pop_task    (q_pop_task)
   );

   prqs_level_find #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_level_find (
      .level_mask (q_mask),
      .cur_level  (cl_ff),
      .top_level  (top_level),
      .find       (find)
   );

   // configuration port: the user must write it only while the block is idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_preempt_ff      <= 1'b1;
         cfg_rr_ff           <= 1'b1;
         cfg_slice_ff        <= prqs_pkg::SLICE_RESET;
         cfg_idle_id_ff      <= '0;
         cfg_idle_present_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            prqs_pkg::CSR_PREEMPT_ENABLE:     cfg_preempt_ff      <= csr_wdata[0];
            prqs_pkg::CSR_ROUND_ROBIN_ENABLE: cfg_rr_ff           <= csr_wdata[0];
            prqs_pkg::CSR_SLICE_LENGTH:       cfg_slice_ff        <= csr_wdata[7:0];
            prqs_pkg::CSR_IDLE_TASK_ID:       cfg_idle_id_ff      <= csr_wdata[4:0];
            prqs_pkg::CSR_IDLE_PRESENT:       cfg_idle_present_ff <= csr_wdata[0];
            default: begin
               cfg_preempt_ff <= cfg_preempt_ff;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         cur_ff       <= '0;
         cl_ff        <= '0;
         cv_ff        <= 1'b0;
         cr_ff        <= 1'b0;
         sc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!busy) req_valid_ff <= start;
         phase_ff     <= busy;
         cur_ff       <= cur_in;
         cl_ff        <= cl_in;
         cv_ff        <= cv_in;
         cr_ff        <= cr_in;
         sc_ff        <= sc_in;
         rsp_valid_ff <= req_valid_ff && !busy;
      end
   end

   // input word and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_kind_ff  <= prqs_pkg::kind_type'(req_kind);
         req_task_ff  <= req_task_id;
         req_level_ff <= req_task_level;
      end
      rsp_task_ff    <= cv_in ? cur_in : 5'd0;
      rsp_nvalid_ff  <= cv_in;
      rsp_resched_ff <= resched_in;
      rsp_ign_ff     <= ign_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_task  = rsp_task_ff;
   assign rsp_next_valid = rsp_nvalid_ff;
   assign rsp_reschedule = rsp_resched_ff;
   assign rsp_ignored    = rsp_ign_ff;

   // a pick raises busy only for its re-queue pass, and its result is registered after the pop pass
   `ASSERT_NEXT(a_busy_single, clock, reset, busy, !busy)
   `ASSERT_IMPLY(a_pick_result, clock, reset, busy, ##2 rsp_valid)
   // a running task is always a current task
   `ASSERT_IMPLY(a_running_valid, clock, reset, cr_ff, cv_ff)
   `ASSERT_IMPLY(a_no_task_zero, clock, reset, rsp_valid && !rsp_next_valid,
      rsp_next_task == 5'd0)

endmodule

/* hdl/prqs_level_find.sv */
// Level bitmap search: highest non-empty level and checks against the current level.
// Depends on prqs_pkg.
module prqs_level_find #(
   parameter int unsigned NUM_LEVELS = 32
) (
   input  logic [NUM_LEVELS-1:0]         level_mask,
   input  logic [$clog2(NUM_LEVELS)-1:0] cur_level,
   output logic [$clog2(NUM_LEVELS)-1:0] top_level,
   output prqs_pkg::find_type            find
);
   localparam int unsigned LW = $clog2(NUM_LEVELS);

   always_comb begin
      top_level   = '0;
      find.any    = |level_mask;
      find.higher = 1'b0;
      find.cur_set = level_mask[cur_level];
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (level_mask[i]) begin
            top_level = LW'(i);
         end
         if (level_mask[i] && (LW'(i) > cur_level)) begin
            find.higher = 1'b1;
         end
      end
   end

endmodule

/* hdl/prqs_queue.sv */
// Per-level ready FIFOs as linked lists over task ids, plus queued bits and level bitmap.
// Depends on prqs_pkg; one enqueue, unlink or pop per cycle.
module prqs_queue #(
   parameter int unsigned NUM_TASKS  = 32,
   parameter int unsigned NUM_LEVELS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  prqs_pkg::qop_type             op,
   input  logic [$clog2(NUM_TASKS)-1:0]  task_idx,
   input  logic [$clog2(NUM_LEVELS)-1:0] level_idx,
   output logic [NUM_LEVELS-1:0]         level_mask,
   output logic                          task_queued,
   output logic [$clog2(NUM_TASKS)-1:0]  pop_task
);
   localparam int unsigned TW = $clog2(NUM_TASKS);
   localparam int unsigned LW = $clog2(NUM_LEVELS);

   logic [NUM_LEVELS-1:0] mask_ff;
   logic [NUM_TASKS-1:0]  queued_ff;
   logic [TW-1:0]         head_ff [NUM_LEVELS];
   logic [TW-1:0]         tail_ff [NUM_LEVELS];
   logic [TW-1:0]         next_ff [NUM_TASKS];
   logic [TW-1:0]         prev_ff [NUM_TASKS];
   logic [LW-1:0]         qlev_ff [NUM_TASKS];

   logic [LW-1:0] ul_level;
   logic [LW-1:0] tail_addr;
   logic [TW-1:0] head_rd;
   logic [TW-1:0] tail_rd;
   logic [TW-1:0] ul_task;
   logic [TW-1:0] next_rd;
   logic [TW-1:0] prev_rd;
   logic          enq_go;
   logic          ul_go;
   logic          h_hit;
   logic          t_hit;

   always_comb begin
      task_queued = queued_ff[task_idx];
      // a pop takes the head of the given level; an unlink finds the level itself
      ul_level  = (op == prqs_pkg::QOP_POP) ? level_idx : qlev_ff[task_idx];
      tail_addr = (op == prqs_pkg::QOP_ENQ) ? level_idx : ul_level;
      head_rd   = head_ff[ul_level];
      tail_rd   = tail_ff[tail_addr];
      ul_task   = (op == prqs_pkg::QOP_POP) ? head_rd : task_idx;
      next_rd   = next_ff[ul_task];
      prev_rd   = prev_ff[ul_task];
      enq_go    = (op == prqs_pkg::QOP_ENQ) && !task_queued;
      ul_go     = ((op == prqs_pkg::QOP_UNLINK) || (op == prqs_pkg::QOP_POP))
                  && queued_ff[ul_task];
      h_hit     = (head_rd == ul_task);
      t_hit     = (tail_rd == ul_task);
   end

   assign level_mask = mask_ff;
   assign pop_task   = head_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         queued_ff <= '0;
      end else begin
         if (enq_go) begin
            mask_ff[level_idx]  <= 1'b1;
            queued_ff[task_idx] <= 1'b1;
         end else if (ul_go) begin
            queued_ff[ul_task] <= 1'b0;
            if (h_hit && t_hit) begin
               mask_ff[ul_level] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enq_go) begin
         if (!mask_ff[level_idx]) begin
            head_ff[level_idx] <= task_idx;
         end else begin
            next_ff[tail_rd]  <= task_idx;
            prev_ff[task_idx] <= tail_rd;
         end
         tail_ff[level_idx] <= task_idx;
         qlev_ff[task_idx]  <= level_idx;
      end else if (ul_go) begin
         if (h_hit && !t_hit) begin
            head_ff[ul_level] <= next_rd;
         end else if (!h_hit && t_hit) begin
            tail_ff[ul_level] <= prev_rd;
         end else if (!h_hit && !t_hit) begin
            next_ff[prev_rd] <= next_rd;
            prev_ff[next_rd] <= prev_rd;
         end
      end
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for priority_ready_queue_scheduler: directed and random
// enqueue/remove/pick/tick words against a cycle-free predictor of the ready queues.
// Depends on prqs_pkg and the scheduler RTL only.

module testbench;

   // stall limit: cycles with no word, response or register write at all
   localparam int unsigned STALL_LIMIT = 2000;

   typedef struct packed {
      logic [4:0] next_task;
      logic       next_valid;
      logic       reschedule;
      logic       ignored;
   } sched_result_type;

   // Mirror of the scheduler: per-level FIFOs as linked lists, a bitmap of
   // non-empty levels, the current task and the slice counter. Every accepted
   // word is applied here and its response queued for comparison.
   class ready_queue_mirror_type;
      bit         preempt_on, rr_on, idle_on;
      bit [7:0]   slice_len;
      bit [4:0]   idle_id;
      bit [31:0]  level_mask, queued;
      bit [4:0]   head [32];
      bit [4:0]   tail [32];
      bit [4:0]   next_link [32];
      bit [4:0]   prev_link [32];
      bit [4:0]   queued_at [32];
      bit [4:0]   cur_task, cur_level;
      bit         cur_valid, cur_running;
      bit [7:0]   slice_cnt;
      sched_result_type awaited_decisions [$];
      int unsigned errors;

      function new();
         preempt_on = 1'b1;
         rr_on = 1'b1;
         slice_len = prqs_pkg::SLICE_RESET;
      endfunction

      function void write_reg(logic [prqs_pkg::CSR_INDEX_W-1:0] idx,
                              logic [prqs_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            prqs_pkg::CSR_PREEMPT_ENABLE:     preempt_on = data[0];
            prqs_pkg::CSR_ROUND_ROBIN_ENABLE: rr_on = data[0];
            prqs_pkg::CSR_SLICE_LENGTH:       slice_len = data;
            prqs_pkg::CSR_IDLE_TASK_ID:       idle_id = data[4:0];
            prqs_pkg::CSR_IDLE_PRESENT:       idle_on = data[0];
            default: ;
         endcase
      endfunction

      function bit is_idle(bit [4:0] t);
         return idle_on && t == idle_id;
      endfunction

      // append to the tail of its level; refuse a task already queued
      function bit link_in(bit [4:0] t, bit [4:0] lvl);
         if (queued[t]) return 1'b0;
         if (!level_mask[lvl]) begin
            head[lvl] = t;
         end else begin
            next_link[tail[lvl]] = t;
            prev_link[t] = tail[lvl];
         end
         tail[lvl] = t;
         level_mask[lvl] = 1'b1;
         queued[t] = 1'b1;
         queued_at[t] = lvl;
         return 1'b1;
      endfunction

      // unlink from the level it was queued at; head/tail links stay stale
      function bit unlink(bit [4:0] t);
         bit [4:0] lvl, p, n;
         if (!queued[t]) return 1'b0;
         lvl = queued_at[t];
         if (head[lvl] == t && tail[lvl] == t) begin
            level_mask[lvl] = 1'b0;
         end else if (head[lvl] == t) begin
            head[lvl] = next_link[t];
         end else if (tail[lvl] == t) begin
            tail[lvl] = prev_link[t];
         end else begin
            p = prev_link[t];
            n = next_link[t];
            next_link[p] = n;
            prev_link[n] = p;
         end
         queued[t] = 1'b0;
         return 1'b1;
      endfunction

      function void note_word(prqs_pkg::kind_type kind, logic [4:0] id, logic [4:0] lvl);
         sched_result_type want;
         bit was_running;
         bit [31:0] above;
         bit [4:0] popped;
         int top;
         want = '0;
         case (kind)
            prqs_pkg::KIND_ENQUEUE: want.ignored = !link_in(id, lvl);
            prqs_pkg::KIND_REMOVE: begin
               was_running = cur_valid && cur_running && cur_task == id;
               want.ignored = !unlink(id) && !was_running;
               if (cur_valid && cur_task == id) cur_running = 1'b0;
            end
            prqs_pkg::KIND_PICK: begin
               // return the running task to its level unless it is the idle task
               if (cur_valid && cur_running) begin
                  cur_running = 1'b0;
                  if (!is_idle(cur_task)) void'(link_in(cur_task, cur_level));
               end
               if (level_mask != '0) begin
                  top = 31;
                  while (!level_mask[top]) top--;
                  popped = head[top];
                  void'(unlink(popped));
                  cur_task = popped;
                  cur_level = 5'(top);
                  cur_valid = 1'b1;
                  cur_running = 1'b1;
               end else if (idle_on) begin
                  cur_task = idle_id;
                  cur_level = '0;
                  cur_valid = 1'b1;
                  cur_running = 1'b1;
               end
            end
            default: begin
               if (preempt_on && cur_valid) begin
                  if (!cur_running || is_idle(cur_task)) begin
                     slice_cnt = '0;
                     want.reschedule = 1'b1;
                  end else if (level_mask != '0) begin
                     above = (cur_level == 5'd31) ? '0
                           : ~((32'd1 << (int'(cur_level) + 1)) - 32'd1);
                     if ((level_mask & above) != '0) begin
                        slice_cnt = '0;
                        want.reschedule = 1'b1;
                     end else if (rr_on && level_mask[cur_level]) begin
                        if (slice_cnt != prqs_pkg::SLICE_MAX) slice_cnt++;
                        if (slice_cnt >= slice_len) begin
                           slice_cnt = '0;
                           want.reschedule = 1'b1;
                        end
                     end
                  end
               end
            end
         endcase
         want.next_valid = cur_valid;
         want.next_task = cur_valid ? cur_task : 5'd0;
         awaited_decisions.push_back(want);
      endfunction

      function void check_word(logic [4:0] task_seen, logic valid_seen,
                               logic resched_seen, logic ign_seen);
         sched_result_type want, got;
         got = {task_seen, valid_seen, resched_seen, ign_seen};
         if (awaited_decisions.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: task %0d valid %b resched %b ignored %b",
                        got.next_task, got.next_valid, got.reschedule, got.ignored);
            return;
         end
         want = awaited_decisions.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("mismatch (task valid resched ignored): exp %0d %b %b %b got %0d %b %b %b",
                        want.next_task, want.next_valid, want.reschedule, want.ignored,
                        got.next_task, got.next_valid, got.reschedule, got.ignored);
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [1:0]                       req_kind = '0;
   logic [4:0]                       req_task_id = '0;
   logic [4:0]                       req_task_level = '0;
   logic                             rsp_valid;
   logic [4:0]                       rsp_next_task;
   logic                             rsp_next_valid;
   logic                             rsp_reschedule;
   logic                             rsp_ignored;
   logic                             csr_we = 1'b0;
   logic [prqs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [prqs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   ready_queue_mirror_type board = new();
   int unsigned stall_cycles = 0;

   priority_ready_queue_scheduler i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_task_id    (req_task_id),
      .req_task_level (req_task_level),
      .rsp_valid      (rsp_valid),
      .rsp_next_task  (rsp_next_task),
      .rsp_next_valid (rsp_next_valid),
      .rsp_reschedule (rsp_reschedule),
      .rsp_ignored    (rsp_ignored),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Present one word and hold it until the block takes it. Start stays high
   // on return so back-to-back words need no second assignment in one step.
   task automatic send_word(prqs_pkg::kind_type kind, logic [4:0] id, logic [4:0] lvl);
      start <= 1'b1;
      req_kind <= kind;
      req_task_id <= id;
      req_task_level <= lvl;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_word(kind, id, lvl);
   endtask

   // Drop start for a gap given by n; scramble the request fields meanwhile.
   task automatic idle_gap(int unsigned n);
      start <= 1'b0;
      req_kind <= 2'($urandom());
      req_task_id <= 5'($urandom());
      req_task_level <= 5'($urandom());
      repeat (n) @(posedge clock);
   endtask

   // Hold off new words until every response has come back.
   task automatic drain();
      start <= 1'b0;
      while (board.awaited_decisions.size() != 0) @(posedge clock);
   endtask

   // Write one register; the caller lowers the write enable after the last one.
   task automatic put_csr(logic [prqs_pkg::CSR_INDEX_W-1:0] idx,
                          logic [prqs_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(idx, data);
   endtask

   // Mostly back to back, often a short gap, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   initial begin : stimulus
      logic               preempt_cfg, rr_cfg, idle_on_cfg, gaps_on;
      logic [7:0]         slice_cfg;
      logic [4:0]         idle_id_cfg, lvl_hi, id, lvl;
      prqs_pkg::kind_type kind;
      int unsigned        r, gap;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty scheduler, refused enqueue of a queued task, removal of
      // the running task, reinsertion of the current task, unlink from head,
      // middle and tail, preemption by a higher level, extremes of id and level.
      send_word(prqs_pkg::KIND_PICK, 5'd31, 5'd31);      // nothing ready, no idle task
      send_word(prqs_pkg::KIND_TICK, 5'd17, 5'd9);       // no current task
      send_word(prqs_pkg::KIND_REMOVE, 5'd9, 5'd0);      // not queued, not running
      send_word(prqs_pkg::KIND_ENQUEUE, 5'd31, 5'd31);
      send_word(prqs_pkg::KIND_ENQUEUE, 5'd0, 5'd0);
      send_word(prqs_pkg::KIND_ENQUEUE, 5'd5, 5'd31);
      send_word(prqs_pkg::KIND_ENQUEUE, 5'd31, 5'd4);    // already queued
      send_word(prqs_pkg::KIND_PICK, 5'd0, 5'd0);
      send_word(prqs_pkg::KIND_TICK, 5'd0, 5'd0);        // peer at the top level: count
      send_word(prqs_pkg::KIND_ENQUEUE, 5'd31, 5'd31);   // current task back in its queue
      send_word(prqs_pkg::KIND_PICK, 5'd10, 5'd21);      // requeue refused, pop next
      send_word(prqs_pkg::KIND_REMOVE, 5'd5, 5'd13);     // running current: stop it
      send_word(prqs_pkg::KIND_TICK, 5'd0, 5'd0);        // current not running
      send_word(prqs_pkg::KIND_PICK, 5'd0, 5'd0);
      send_word(prqs_pkg::KIND_ENQUEUE, 5'd1, 5'd4);
      send_word(prqs_pkg::KIND_ENQUEUE, 5'd2, 5'd4);
      send_word(prqs_pkg::KIND_ENQUEUE, 5'd3, 5'd4);
      send_word(prqs_pkg::KIND_ENQUEUE, 5'd4, 5'd4);
      send_word(prqs_pkg::KIND_REMOVE, 5'd2, 5'd0);      // middle
      send_word(prqs_pkg::KIND_REMOVE, 5'd4, 5'd0);      // tail
      send_word(prqs_pkg::KIND_REMOVE, 5'd1, 5'd0);      // head
      send_word(prqs_pkg::KIND_TICK, 5'd0, 5'd0);        // own level empty
      send_word(prqs_pkg::KIND_REMOVE, 5'd31, 5'd31);
      send_word(prqs_pkg::KIND_PICK, 5'd0, 5'd0);
      send_word(prqs_pkg::KIND_ENQUEUE, 5'd30, 5'd17);
      send_word(prqs_pkg::KIND_TICK, 5'd0, 5'd0);        // higher level waiting

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin preempt_cfg = 1'b1; rr_cfg = 1'b1; slice_cfg = 8'd10; idle_id_cfg = 5'd0;
                     idle_on_cfg = 1'b0; lvl_hi = 5'd3; gaps_on = 1'b0; end
            1: begin preempt_cfg = 1'b1; rr_cfg = 1'b1; slice_cfg = 8'd1; idle_id_cfg = 5'd31;
                     idle_on_cfg = 1'b1; lvl_hi = 5'd3; gaps_on = 1'b1; end
            2: begin preempt_cfg = 1'b0; rr_cfg = 1'b1; slice_cfg = 8'd4; idle_id_cfg = 5'd5;
                     idle_on_cfg = 1'b1; lvl_hi = 5'd31; gaps_on = 1'b1; end
            3: begin preempt_cfg = 1'b1; rr_cfg = 1'b0; slice_cfg = 8'd3; idle_id_cfg = 5'd0;
                     idle_on_cfg = 1'b1; lvl_hi = 5'd3; gaps_on = 1'b1; end
            4: begin preempt_cfg = 1'b1; rr_cfg = 1'b1; slice_cfg = 8'd255; idle_id_cfg = 5'd31;
                     idle_on_cfg = 1'b0; lvl_hi = 5'd7; gaps_on = 1'b1; end
            5: begin preempt_cfg = 1'b1; rr_cfg = 1'b1; slice_cfg = 8'd0; idle_id_cfg = 5'd17;
                     idle_on_cfg = 1'b1; lvl_hi = 5'd1; gaps_on = 1'b1; end
            6: begin preempt_cfg = 1'b1; rr_cfg = 1'b1; slice_cfg = 8'd2; idle_id_cfg = 5'd0;
                     idle_on_cfg = 1'b0; lvl_hi = 5'd31; gaps_on = 1'b1; end
            default: begin preempt_cfg = 1'b1; rr_cfg = 1'b1; slice_cfg = 8'd5;
                     idle_id_cfg = 5'd3; idle_on_cfg = 1'b1; lvl_hi = 5'd3;
                     gaps_on = 1'b1; end
         endcase

         // reconfigure only with the block idle: drain, let it settle, write
         drain();
         repeat (4) @(posedge clock);
         put_csr(prqs_pkg::CSR_PREEMPT_ENABLE, 8'(preempt_cfg));
         put_csr(prqs_pkg::CSR_ROUND_ROBIN_ENABLE, 8'(rr_cfg));
         put_csr(prqs_pkg::CSR_SLICE_LENGTH, slice_cfg);
         put_csr(prqs_pkg::CSR_IDLE_TASK_ID, 8'(idle_id_cfg));
         put_csr(prqs_pkg::CSR_IDLE_PRESENT, 8'(idle_on_cfg));
         csr_we <= 1'b0;

         // Random words over a small pool of tasks and a narrow band of levels,
         // so queues grow several deep and peers share a level.
         repeat (50) begin
            r = $urandom_range(99, 0);
            if (r < 35) kind = prqs_pkg::KIND_ENQUEUE;
            else if (r < 50) kind = prqs_pkg::KIND_REMOVE;
            else if (r < 70) kind = prqs_pkg::KIND_PICK;
            else kind = prqs_pkg::KIND_TICK;
            id = ($urandom_range(9, 0) < 7) ? 5'($urandom_range(11, 0)) : 5'($urandom());
            lvl = ($urandom_range(9, 0) < 8) ? 5'($urandom_range(int'(lvl_hi), 0))
                                             : 5'($urandom());
            send_word(kind, id, lvl);
            if ($urandom_range(39, 0) == 0) drain();
            if (gaps_on) begin
               gap = pick_gap();
               if (gap != 0) idle_gap(gap);
            end
         end

         // Put two peers on the top level, run one, and tick past a full slice.
         send_word(prqs_pkg::KIND_ENQUEUE, 5'd20, 5'd31);
         send_word(prqs_pkg::KIND_ENQUEUE, 5'd21, 5'd31);
         send_word(prqs_pkg::KIND_PICK, 5'd0, 5'd0);
         repeat (int'(slice_cfg) + 8)
            send_word(prqs_pkg::KIND_TICK, 5'($urandom()), 5'($urandom()));
      end

      drain();
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.awaited_decisions.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Compare every strobed response; an unknown strobe counts as a response.
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0)
         board.check_word(rsp_next_task, rsp_next_valid, rsp_reschedule, rsp_ignored);
   end

   // Advance the stall count on cycles with no traffic at all; drop the run
   // when the block stops moving.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: %0d responses outstanding", board.awaited_decisions.size());
         $display("status: fail");
         $finish;
      end
   end

endmodule
